[rtl/tfl_pkg.sv]
`default_nettype none

package tfl_pkg;

    localparam int VERTEX_W = 32;
    localparam int SHORT_INDEX_W = 16;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INDEXED_MODE  = 2'd0,
        REG_INDEX_IS_WIDE = 2'd1,
        REG_BASE_VERTEX   = 2'd2,
        REG_FIRST_VERTEX  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEEN_NONE = 2'd0,
        SEEN_HUB  = 2'd1,
        SEEN_EDGE = 2'd2,
        SEEN_ODD  = 2'd3
    } seen_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] hub_vertex;
        logic [VERTEX_W-1:0] edge_first;
        logic [VERTEX_W-1:0] edge_second;
        logic                last_triangle;
    } result_t;

endpackage

`default_nettype wire

[rtl/triangle_fan_to_list_indices.sv]
`default_nettype none

// Turns triangle fans into independent triangles (hub, previous, current), one triangle
// for every fan vertex from the third onward. Vertices enter one per cycle into an input
// register; the vertex number is formed there and the triangle is written into a
// two-entry output buffer, so a new vertex is accepted every cycle while the output side
// keeps up; a triangle is offered once its vertex moves into the output buffer. The input
// stalls only while a vertex is held and the buffer is full. The configuration port is
// always ready; the user must write it only while no vertex is in flight (not enforced).
module triangle_fan_to_list_indices
    import tfl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [VERTEX_W-1:0]    cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [VERTEX_W-1:0]    vertex_index,
    input  wire logic                   fan_start,
    input  wire logic                   fan_end,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [VERTEX_W-1:0]         hub_vertex,
    output logic [VERTEX_W-1:0]         edge_first,
    output logic [VERTEX_W-1:0]         edge_second,
    output logic                        last_triangle
);

    logic                indexed_mode_reg;
    logic                index_is_wide_reg;
    logic [VERTEX_W-1:0] base_vertex_reg;
    logic [VERTEX_W-1:0] first_vertex_reg;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [VERTEX_W-1:0] s1_index_reg;
    logic                s1_start_reg;
    logic                s1_end_reg;

    logic [VERTEX_W-1:0] hub_reg;
    logic [VERTEX_W-1:0] prev_reg;
    seen_t               seen_reg;
    seen_t               seen_next;
    logic [VERTEX_W-1:0] seq_reg;
    logic [VERTEX_W-1:0] seq_next;

    logic                in_accept;
    logic                advance;
    logic                buf_room;
    logic                fan_open;
    seen_t               seen_eff;
    logic [VERTEX_W-1:0] seq_eff;
    logic [VERTEX_W-1:0] idx_eff;
    logic [VERTEX_W-1:0] vertex_num;
    logic                emit;
    result_t             result;
    result_t             out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            indexed_mode_reg  <= 1'b0;
            index_is_wide_reg <= 1'b0;
            base_vertex_reg   <= '0;
            first_vertex_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INDEXED_MODE:  indexed_mode_reg  <= cfg_data[0];
                REG_INDEX_IS_WIDE: index_is_wide_reg <= cfg_data[0];
                REG_BASE_VERTEX:   base_vertex_reg   <= cfg_data;
                REG_FIRST_VERTEX:  first_vertex_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance   = s1_valid_reg && buf_room;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = in_accept || (s1_valid_reg && !advance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_index_reg <= vertex_index;
            s1_start_reg <= fan_start;
            s1_end_reg   <= fan_end;
        end
    end

    // A vertex that arrives with no fan open starts one, exactly as a marked start does.
    always_comb
    begin
        fan_open = s1_start_reg || (seen_reg == SEEN_NONE);
        seen_eff = fan_open ? SEEN_NONE : seen_reg;
        seq_eff  = fan_open ? '0 : seq_reg;
        idx_eff  = index_is_wide_reg ? s1_index_reg
                 : {{(VERTEX_W-SHORT_INDEX_W){1'b0}}, s1_index_reg[SHORT_INDEX_W-1:0]};
        vertex_num = indexed_mode_reg ? (base_vertex_reg + idx_eff)
                   : (first_vertex_reg + seq_eff);
        emit = (seen_eff == SEEN_EDGE) || (seen_eff == SEEN_ODD);

        if (s1_end_reg)
        begin
            seen_next = SEEN_NONE;
            seq_next  = '0;
        end
        else
        begin
            seen_next = (seen_eff == SEEN_NONE) ? SEEN_HUB : SEEN_EDGE;
            seq_next  = seq_eff + VERTEX_W'(1);
        end

        result.hub_vertex    = hub_reg;
        result.edge_first    = prev_reg;
        result.edge_second   = vertex_num;
        result.last_triangle = s1_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hub_reg  <= '0;
            prev_reg <= '0;
            seen_reg <= SEEN_NONE;
            seq_reg  <= '0;
        end
        else if (advance)
        begin
            seen_reg <= seen_next;
            seq_reg  <= seq_next;
            if (seen_eff == SEEN_NONE)
            begin
                hub_reg <= vertex_num;
            end
            else
            begin
                prev_reg <= vertex_num;
            end
        end
    end

    tfl_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && emit),
        .push_data (result),
        .room      (buf_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign hub_vertex    = out_data.hub_vertex;
    assign edge_first    = out_data.edge_first;
    assign edge_second   = out_data.edge_second;
    assign last_triangle = out_data.last_triangle;

`ifndef SYNTH
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("Input stalled with no item held in the input register.");

    a_end_closes_fan: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_end_reg) |=> (seen_reg == SEEN_NONE) && (seq_reg == '0))
        else $error("Fan still open after its closing vertex.");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg && $stable(s1_index_reg))
        else $error("Held item lost from the input register.");

    a_second_vertex_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (seen_eff == SEEN_NONE || seen_eff == SEEN_HUB)) |-> !emit)
        else $error("Triangle emitted before the fan had two vertices.");
`endif

endmodule

`default_nettype wire

[rtl/tfl_out_buf.sv]
`default_nettype none

module tfl_out_buf
    import tfl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_data
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    slot0_reg;
    result_t    slot1_reg;
    logic       pop;

    assign pop       = (count_reg != 2'd0) && !out_stall;
    assign room      = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                slot0_reg <= slot1_reg;
                if (push)
                begin
                    slot1_reg <= push_data;
                end
            end
            else if (push)
            begin
                slot0_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= push_data;
            end
            else
            begin
                slot1_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

[sim/triangle_fan_to_list_indices_tb.sv]
`timescale 1ns / 100ps

module triangle_fan_to_list_indices_tb;
    import tfl_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 650;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 80;

    typedef struct {
        bit                  cfg_row;
        cfg_reg_t            reg_sel;
        logic [VERTEX_W-1:0] value;
        logic [VERTEX_W-1:0] idx;
        bit                  start;
        bit                  fin;
        bit                  typed;
        bit                  typed_hit;
        result_t             typed_tri;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [VERTEX_W-1:0]    cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [VERTEX_W-1:0]    vertex_index;
    logic                   fan_start;
    logic                   fan_end;
    logic                   out_valid;
    logic                   out_stall;
    logic [VERTEX_W-1:0]    hub_vertex;
    logic [VERTEX_W-1:0]    edge_first;
    logic [VERTEX_W-1:0]    edge_second;
    logic                   last_triangle;

    // Predicted block state and register copies.
    bit                  cfg_indexed;
    bit                  cfg_wide;
    logic [VERTEX_W-1:0] cfg_base;
    logic [VERTEX_W-1:0] cfg_first;
    logic [VERTEX_W-1:0] fan_hub;
    logic [VERTEX_W-1:0] fan_prev;
    seen_t               fan_seen;
    logic [VERTEX_W-1:0] fan_pos;

    result_t   triangles_due[$];
    plan_row_t plan[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  tx_quiet;
    bit  rx_quiet;
    int  rx_wait;
    int  long_hold_left;
    int  hold_asked;
    int  hold_given;

    triangle_fan_to_list_indices dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .vertex_index  (vertex_index),
        .fan_start     (fan_start),
        .fan_end       (fan_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hub_vertex    (hub_vertex),
        .edge_first    (edge_first),
        .edge_second   (edge_second),
        .last_triangle (last_triangle)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("ERROR at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic step_fan(input logic [VERTEX_W-1:0] idx, input bit start, input bit fin,
                            output bit hit, output result_t tri_out);
        logic [VERTEX_W-1:0] num;
        hit = 1'b0;
        tri_out = '0;
        if (start || fan_seen == SEEN_NONE)
        begin
            fan_seen = SEEN_NONE;
            fan_pos = '0;
        end
        if (cfg_indexed)
            num = cfg_base + (cfg_wide ? idx
                  : {{(VERTEX_W-SHORT_INDEX_W){1'b0}}, idx[SHORT_INDEX_W-1:0]});
        else
            num = cfg_first + fan_pos;
        fan_pos = fan_pos + 1;
        case (fan_seen)
            SEEN_NONE:
            begin
                fan_hub = num;
                fan_seen = SEEN_HUB;
            end
            SEEN_HUB:
            begin
                fan_prev = num;
                fan_seen = SEEN_EDGE;
            end
            default:
            begin
                hit = 1'b1;
                tri_out.hub_vertex = fan_hub;
                tri_out.edge_first = fan_prev;
                tri_out.edge_second = num;
                tri_out.last_triangle = fin;
                fan_prev = num;
                fan_seen = SEEN_EDGE;
            end
        endcase
        if (fin)
        begin
            fan_seen = SEEN_NONE;
            fan_pos = '0;
        end
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [VERTEX_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (sel)
            REG_INDEXED_MODE:  cfg_indexed = value[0];
            REG_INDEX_IS_WIDE: cfg_wide = value[0];
            REG_BASE_VERTEX:   cfg_base = value;
            REG_FIRST_VERTEX:  cfg_first = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic offer_vertex(input logic [VERTEX_W-1:0] idx, input bit start, input bit fin,
                                input bit typed, input bit typed_hit,
                                input result_t typed_tri);
        int      gap;
        bit      hit;
        result_t tri_out;
        gap = tx_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        vertex_index <= idx;
        fan_start <= start;
        fan_end <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        step_fan(idx, start, fin, hit, tri_out);
        if (typed)
        begin
            hit = typed_hit;
            tri_out = typed_tri;
        end
        if (hit)
            triangles_due.push_back(tri_out);
    endtask

    // A vertex may still be in flight without any triangle pending, hence the extra cycles.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (triangles_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_cfg_row(input cfg_reg_t sel, input logic [VERTEX_W-1:0] value);
        plan_row_t row;
        row = '{reg_sel: REG_INDEXED_MODE, default: '0};
        row.cfg_row = 1'b1;
        row.reg_sel = sel;
        row.value = value;
        plan.push_back(row);
    endtask

    task automatic add_vertex_row(input logic [VERTEX_W-1:0] idx, input bit start,
                                  input bit fin);
        plan_row_t row;
        row = '{reg_sel: REG_INDEXED_MODE, default: '0};
        row.idx = idx;
        row.start = start;
        row.fin = fin;
        plan.push_back(row);
    endtask

    task automatic add_typed_row(input logic [VERTEX_W-1:0] idx, input bit start, input bit fin,
                                 input bit hit, input logic [VERTEX_W-1:0] hub,
                                 input logic [VERTEX_W-1:0] first,
                                 input logic [VERTEX_W-1:0] second, input bit last_tri);
        plan_row_t row;
        row = '{reg_sel: REG_INDEXED_MODE, default: '0};
        row.idx = idx;
        row.start = start;
        row.fin = fin;
        row.typed = 1'b1;
        row.typed_hit = hit;
        row.typed_tri.hub_vertex = hub;
        row.typed_tri.edge_first = first;
        row.typed_tri.edge_second = second;
        row.typed_tri.last_triangle = last_tri;
        plan.push_back(row);
    endtask

    function automatic logic [VERTEX_W-1:0] pick_word();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 20);
            3:       return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VERTEX_W-1:0] pick_index();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 32'h0000_FFFF);
            3:       return {16'($urandom_range(0, 3)), 16'hFFFF};
            default: return $urandom;
        endcase
    endfunction

    // Output side: checks every accepted triangle and draws its own stall pattern.
    always @(posedge clk)
    begin : rx_side
        result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait = 0;
            long_hold_left = 0;
            hold_given = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (triangles_due.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected triangle %h %h %h %b",
                                  hub_vertex, edge_first, edge_second, last_triangle));
                end
                else
                begin
                    want = triangles_due.pop_front();
                    if (hub_vertex !== want.hub_vertex)
                        note_mismatch($sformatf("hub_vertex %h, wanted %h",
                                      hub_vertex, want.hub_vertex));
                    if (edge_first !== want.edge_first)
                        note_mismatch($sformatf("edge_first %h, wanted %h",
                                      edge_first, want.edge_first));
                    if (edge_second !== want.edge_second)
                        note_mismatch($sformatf("edge_second %h, wanted %h",
                                      edge_second, want.edge_second));
                    if (last_triangle !== want.last_triangle)
                        note_mismatch($sformatf("last_triangle %b, wanted %b",
                                      last_triangle, want.last_triangle));
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 17);
            end
            if (hold_asked != hold_given)
            begin
                hold_given = hold_asked;
                long_hold_left = LONG_HOLD_CYCLES;
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        int sent;
        int budget;
        int done_here;
        int fan_len;
        bit start;
        bit fin;

        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_INDEXED_MODE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        vertex_index <= '0;
        fan_start <= 1'b0;
        fan_end <= 1'b0;
        cfg_indexed = 1'b0;
        cfg_wide = 1'b0;
        cfg_base = '0;
        cfg_first = '0;
        fan_hub = '0;
        fan_prev = '0;
        fan_seen = SEEN_NONE;
        fan_pos = '0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        hold_asked = 0;

        // Sequential numbering straight after reset, then the short-fan cases.
        add_typed_row(32'h0000_1234, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_typed_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_typed_row(32'h0000_0000, 1'b0, 1'b0, 1'b1, 32'd0, 32'd1, 32'd2, 1'b0);
        add_typed_row(32'h8000_0000, 1'b0, 1'b1, 1'b1, 32'd0, 32'd2, 32'd3, 1'b1);
        add_typed_row(32'h0000_0005, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0);
        add_vertex_row(32'h0000_0006, 1'b0, 1'b0);
        add_vertex_row(32'h0000_0007, 1'b0, 1'b1);
        // Sequential numbers wrapping past the top of the range.
        add_cfg_row(REG_FIRST_VERTEX, 32'hFFFF_FFFE);
        add_typed_row(32'h0, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_typed_row(32'h0, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_typed_row(32'h0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        add_typed_row(32'h0, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFE, 32'h0, 32'h1, 1'b1);
        // Narrow indices, and a new fan started while one is open.
        add_cfg_row(REG_INDEXED_MODE, 32'h1);
        add_typed_row(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_typed_row(32'h0000_0000, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_typed_row(32'h1234_5678, 1'b0, 1'b0, 1'b1, 32'hFFFF, 32'h0, 32'h5678, 1'b0);
        add_typed_row(32'h0000_ABCD, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_typed_row(32'h0000_0001, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_typed_row(32'h0000_0002, 1'b0, 1'b1, 1'b1, 32'hABCD, 32'h1, 32'h2, 1'b1);
        // Wide indices with a base that wraps.
        add_cfg_row(REG_INDEX_IS_WIDE, 32'h1);
        add_cfg_row(REG_BASE_VERTEX, 32'hFFFF_FFFF);
        add_typed_row(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_typed_row(32'h0000_0000, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        add_typed_row(32'h0000_0001, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0,
                      1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < plan.size(); i++)
        begin
            if (plan[i].cfg_row)
            begin
                settle_block();
                write_reg(plan[i].reg_sel, plan[i].value);
            end
            else
            begin
                offer_vertex(plan[i].idx, plan[i].start, plan[i].fin, plan[i].typed,
                             plan[i].typed_hit, plan[i].typed_tri);
            end
        end

        phase = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle_block();
            if (phase == 0 || $urandom_range(0, 1) == 0)
                write_reg(REG_INDEXED_MODE, $urandom_range(0, 1));
            if (phase == 0 || $urandom_range(0, 1) == 0)
                write_reg(REG_INDEX_IS_WIDE, $urandom_range(0, 1));
            if (phase == 0 || $urandom_range(0, 1) == 0)
                write_reg(REG_BASE_VERTEX, pick_word());
            if (phase == 0 || $urandom_range(0, 1) == 0)
                write_reg(REG_FIRST_VERTEX, pick_word());
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            // The output side holds off for a long stretch while vertices keep coming.
            if (phase == 2)
            begin
                tx_quiet = 1'b1;
                hold_asked++;
            end
            budget = $urandom_range(30, 70);
            done_here = 0;
            while (done_here < budget)
            begin
                fan_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
                          : $urandom_range(3, 12);
                for (int k = 0; k < fan_len; k++)
                begin
                    start = (k == 0);
                    fin = (k == fan_len - 1);
                    if ($urandom_range(0, 9) == 0)
                        start = $urandom_range(0, 1);
                    if ($urandom_range(0, 9) == 0)
                        fin = $urandom_range(0, 1);
                    offer_vertex(pick_index(), start, fin, 1'b0, 1'b0, '0);
                    done_here++;
                    sent++;
                    if (phase == 4 && done_here == budget / 2)
                        settle_block();
                end
            end
            phase++;
        end

        settle_block();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
